// ===== rtl/dsdv_pkg.sv =====
// Package: shared constants, types and command/status structs for the route table engine.
package dsdv_pkg;

  localparam int NODES  = 64;
  localparam int ID_W   = 6;
  localparam int COST_W = 16;
  localparam int SEQ_W  = 32;
  localparam int CNT_W  = $clog2(NODES + 1);

  localparam logic [1:0] MODE_ADV  = 2'd0;
  localparam logic [1:0] MODE_LINK = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic CFG_SELF = 1'b0;
  localparam logic CFG_INF  = 1'b1;
  localparam int   CFG_W    = 16;

  localparam logic [COST_W-1:0] INF_RESET = 16'hFFFF;

  typedef struct packed {
    logic [ID_W-1:0]   hop;
    logic [COST_W-1:0] cost;
    logic [SEQ_W-1:0]  seq;
  } rt_data_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_ITEM,
    RD_SWEEP,
    RD_SELF
  } rd_sel_t;

  typedef struct packed {
    logic            load;
    rd_sel_t         rd_sel;
    logic [ID_W-1:0] sweep_idx;
    logic            exec;
    logic            sweep_wr;
    logic            self_wr;
    logic            res_exec;
    logic            res_rd;
  } cmd_t;

  typedef struct packed {
    logic link;
    logic sweep_req;
    logic bump;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/dsdv_ctrl.sv =====
// Controller: sequences reads, updates, sweeps and result loading for one item.
module dsdv_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dsdv_pkg::sts_t sts,
  output dsdv_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SWEEP,
    S_SELF_RD,
    S_SELF_WR,
    S_RES_RD,
    S_RES
  } state_t;

  localparam logic [dsdv_pkg::CNT_W-1:0] CNT_END = dsdv_pkg::CNT_W'(dsdv_pkg::NODES);

  state_t                     state_r, state_nxt;
  logic [dsdv_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // Decode commands and next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.rd_sel = dsdv_pkg::RD_NONE;
    cmd.sweep_idx = cnt_r[dsdv_pkg::ID_W-1:0];
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_sel = dsdv_pkg::RD_ITEM;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        if (!sts.link) begin
          if (sts.out_free) begin
            cmd.exec     = 1'b1;
            cmd.res_exec = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.exec = 1'b1;
          cnt_nxt  = '0;
          if (sts.sweep_req) begin
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_SELF_RD;
          end
        end
      end
      S_SWEEP: begin
        if (cnt_r != CNT_END) begin
          cmd.rd_sel = dsdv_pkg::RD_SWEEP;
        end
        cmd.sweep_wr = (cnt_r != '0);
        cnt_nxt = cnt_r + dsdv_pkg::CNT_W'(1);
        if (cnt_r == CNT_END) begin
          state_nxt = S_SELF_RD;
        end
      end
      S_SELF_RD: begin
        if (sts.bump) begin
          cmd.rd_sel = dsdv_pkg::RD_SELF;
          state_nxt  = S_SELF_WR;
        end else begin
          cmd.rd_sel = dsdv_pkg::RD_ITEM;
          state_nxt  = S_RES;
        end
      end
      S_SELF_WR: begin
        cmd.self_wr = 1'b1;
        state_nxt   = S_RES_RD;
      end
      S_RES_RD: begin
        cmd.rd_sel = dsdv_pkg::RD_ITEM;
        state_nxt  = S_RES;
      end
      S_RES: begin
        if (sts.out_free) begin
          cmd.res_rd = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/dsdv_dpath.sv =====
// Datapath: route and neighbor tables, update arithmetic, config and result register.
module dsdv_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsdv_pkg::cmd_t                cmd,
  output dsdv_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [dsdv_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [1:0]                    in_mode,
  input  logic [dsdv_pkg::ID_W-1:0]     in_node_id,
  input  logic [dsdv_pkg::ID_W-1:0]     in_dest_id,
  input  logic [dsdv_pkg::COST_W-1:0]   in_cost,
  input  logic [dsdv_pkg::SEQ_W-1:0]    in_seq_in,
  input  logic                          in_link_down,
  input  logic                          in_last_of_batch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_entry_valid,
  output logic [dsdv_pkg::ID_W-1:0]     out_entry_next_hop,
  output logic [dsdv_pkg::COST_W-1:0]   out_entry_cost,
  output logic [dsdv_pkg::SEQ_W-1:0]    out_entry_seq,
  output logic                          out_updated,
  output logic                          out_batch_changed_out
);

  localparam int N = dsdv_pkg::NODES;

  // Configuration
  logic [dsdv_pkg::ID_W-1:0]   self_r;
  logic [dsdv_pkg::COST_W-1:0] inf_r;

  // Latched item
  logic [1:0]                  mode_r;
  logic [dsdv_pkg::ID_W-1:0]   nb_r, dest_r;
  logic [dsdv_pkg::COST_W-1:0] cost_r;
  logic [dsdv_pkg::SEQ_W-1:0]  seq_in_r;
  logic                        down_r, last_r;

  // Tables
  dsdv_pkg::rt_data_t          route_mem [N];
  logic [dsdv_pkg::COST_W-1:0] nbr_mem   [N];
  logic [N-1:0]                route_init_r, route_vld_r, nbr_init_r;

  dsdv_pkg::rt_data_t          rt_q_r, rt_cur, wr_data;
  logic [dsdv_pkg::ID_W-1:0]   rd_idx_r, rd_addr, wr_addr, item_addr;
  logic [dsdv_pkg::COST_W-1:0] nbr_q_r, nbr_cur;
  logic                        rd_en, wr_en, vld_cur, set_vld;

  // Item-level registers
  logic batch_r, bump_r, upd_r, bc_r, out_valid_r;
  dsdv_pkg::rt_data_t out_data_r;
  logic out_ev_r, out_upd_r, out_bc_r;

  // Update arithmetic
  logic [dsdv_pkg::COST_W:0]   sum;
  logic [dsdv_pkg::COST_W-1:0] adv_c, lc;
  logic is_link, is_adv, adv_wr, nb_live, cost_chg, link_ch, nbr_wr, sweep_req;
  logic bc_new, bump_nxt, sweep_hit, out_free;
  dsdv_pkg::rt_data_t link_entry;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      self_r <= '0;
      inf_r  <= dsdv_pkg::INF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dsdv_pkg::CFG_SELF: self_r <= cfg_wdata[dsdv_pkg::ID_W-1:0];
        dsdv_pkg::CFG_INF:  inf_r  <= cfg_wdata[dsdv_pkg::COST_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      nb_r     <= in_node_id;
      dest_r   <= in_dest_id;
      cost_r   <= in_cost;
      seq_in_r <= in_seq_in;
      down_r   <= in_link_down;
      last_r   <= in_last_of_batch;
    end
  end

  assign is_link   = (mode_r == dsdv_pkg::MODE_LINK);
  assign is_adv    = (mode_r == dsdv_pkg::MODE_ADV);
  assign item_addr = is_link ? nb_r : dest_r;

  // Select read address
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = item_addr;
    unique case (cmd.rd_sel)
      dsdv_pkg::RD_NONE:  rd_en   = 1'b0;
      dsdv_pkg::RD_ITEM:  rd_addr = item_addr;
      dsdv_pkg::RD_SWEEP: rd_addr = cmd.sweep_idx;
      dsdv_pkg::RD_SELF:  rd_addr = self_r;
      default:            rd_en   = 1'b0;
    endcase
  end

  // Registered table reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rt_q_r   <= route_mem[rd_addr];
      rd_idx_r <= rd_addr;
    end
    if (cmd.rd_sel == dsdv_pkg::RD_ITEM) begin
      nbr_q_r <= nbr_mem[nb_r];
    end
  end

  // Unwritten entries read as their reset value
  assign rt_cur  = route_init_r[rd_idx_r] ? rt_q_r : '0;
  assign vld_cur = route_vld_r[rd_idx_r];
  assign nbr_cur = nbr_init_r[nb_r] ? nbr_q_r : dsdv_pkg::INF_RESET;

  // Advertised entry: saturating sum and freshness test
  assign sum   = {1'b0, cost_r} + {1'b0, nbr_cur};
  assign adv_c = (sum > {1'b0, inf_r}) ? inf_r : sum[dsdv_pkg::COST_W-1:0];
  assign adv_wr = (dest_r != self_r) &&
                  (!vld_cur || (rt_cur.seq < seq_in_r) ||
                   ((rt_cur.seq == seq_in_r) && (rt_cur.cost > adv_c)));

  // Link report
  assign lc        = down_r ? inf_r : ((cost_r > inf_r) ? inf_r : cost_r);
  assign nb_live   = (nbr_cur < inf_r);
  assign cost_chg  = (nbr_cur != lc);
  assign link_ch   = nb_live ? (down_r || cost_chg) : !down_r;
  assign nbr_wr    = nb_live ? cost_chg : !down_r;
  assign sweep_req = nb_live && cost_chg && vld_cur;
  assign bc_new    = batch_r | link_ch;
  assign bump_nxt  = last_r & bc_new;

  always_comb begin
    link_entry      = rt_cur;
    link_entry.seq  = rt_cur.seq + dsdv_pkg::SEQ_W'(nb_live && down_r);
    link_entry.cost = sweep_req ? lc : rt_cur.cost;
  end

  // Drop routes through the neighbor, except its own entry
  assign sweep_hit = vld_cur && (rt_cur.hop == nb_r) && (rd_idx_r != nb_r);

  // Select the single route write
  always_comb begin
    wr_en   = 1'b0;
    set_vld = 1'b0;
    wr_addr = nb_r;
    wr_data = link_entry;
    priority if (cmd.exec && is_link) begin
      wr_en = 1'b1;
    end else if (cmd.exec && is_adv && adv_wr) begin
      wr_en   = 1'b1;
      set_vld = 1'b1;
      wr_addr = dest_r;
      wr_data = '{hop: nb_r, cost: adv_c, seq: seq_in_r};
    end else if (cmd.sweep_wr && sweep_hit) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_r;
      wr_data = '{hop: rt_cur.hop, cost: inf_r, seq: rt_cur.seq};
    end else if (cmd.self_wr) begin
      wr_en   = 1'b1;
      wr_addr = self_r;
      wr_data = '{hop: rt_cur.hop, cost: rt_cur.cost, seq: rt_cur.seq + 32'd2};
    end else begin
      wr_en = 1'b0;
    end
  end

  // Write tables
  always_ff @(posedge clk) begin
    if (wr_en) begin
      route_mem[wr_addr] <= wr_data;
    end
    if (cmd.exec && is_link && nbr_wr) begin
      nbr_mem[nb_r] <= lc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_init_r <= '0;
      route_vld_r  <= '0;
      nbr_init_r   <= '0;
    end else begin
      if (wr_en) begin
        route_init_r[wr_addr] <= 1'b1;
      end
      if (set_vld) begin
        route_vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.exec && is_link && nbr_wr) begin
        nbr_init_r[nb_r] <= 1'b1;
      end
    end
  end

  // Track batch change and link item outcome
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r <= 1'b0;
      bump_r  <= 1'b0;
    end else if (cmd.exec && is_link) begin
      batch_r <= last_r ? 1'b0 : bc_new;
      bump_r  <= bump_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && is_link) begin
      upd_r <= link_ch | bump_nxt;
      bc_r  <= bump_nxt;
    end
  end

  // Result register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_exec || cmd.res_rd) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_exec) begin
      if (is_adv && adv_wr) begin
        out_ev_r   <= 1'b1;
        out_data_r <= '{hop: nb_r, cost: adv_c, seq: seq_in_r};
        out_upd_r  <= 1'b1;
      end else begin
        out_ev_r   <= vld_cur;
        out_data_r <= rt_cur;
        out_upd_r  <= 1'b0;
      end
      out_bc_r <= 1'b0;
    end else if (cmd.res_rd) begin
      out_ev_r   <= vld_cur;
      out_data_r <= rt_cur;
      out_upd_r  <= upd_r;
      out_bc_r   <= bc_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_entry_valid       = out_ev_r;
  assign out_entry_next_hop    = out_data_r.hop;
  assign out_entry_cost        = out_data_r.cost;
  assign out_entry_seq         = out_data_r.seq;
  assign out_updated           = out_upd_r;
  assign out_batch_changed_out = out_bc_r;

  assign sts.link      = is_link;
  assign sts.sweep_req = sweep_req;
  assign sts.bump      = bump_r;
  assign sts.out_free  = out_free;

  // Checks
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.exec, cmd.sweep_wr, cmd.self_wr}))
    else $error("route table write sources overlap");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.res_exec || cmd.res_rd) |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken item");

  a_bump_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.self_wr |-> !batch_r)
    else $error("batch flag still set at sequence bump");

endmodule

// ===== rtl/dsdv_route_table_engine.sv =====
// Top level: route table engine built from a controller and a datapath.
//
//  channel | direction | handshake               | payload
//  in_     | input     | in_valid / in_ready     | mode, node_id, dest_id, cost, seq_in, ...
//  out_    | output    | out_valid / out_ready   | entry_valid, next_hop, cost, seq, flags
//  cfg_    | input     | cfg_we                  | cfg_addr, cfg_wdata (0 self_id, 1 infinity)
//
// Advertise, read and unknown modes: table read, then update and result load together.
// Link reports: table read, update, entry reread, result load; a batch closing with a change
// adds the own sequence bump (read, write, reread), and a sweep of all NODES entries follows
// the update when a live, routed neighbor's cost changes. The single write port sets this.
// Reset is synchronous; tables read as their reset values until first written.
// A stalled result blocks the next item's final load; that item is accepted meanwhile.
module dsdv_route_table_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_addr,
  input  logic [dsdv_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_mode,
  input  logic [dsdv_pkg::ID_W-1:0]   in_node_id,
  input  logic [dsdv_pkg::ID_W-1:0]   in_dest_id,
  input  logic [dsdv_pkg::COST_W-1:0] in_cost,
  input  logic [dsdv_pkg::SEQ_W-1:0]  in_seq_in,
  input  logic                        in_link_down,
  input  logic                        in_last_of_batch,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_entry_valid,
  output logic [dsdv_pkg::ID_W-1:0]   out_entry_next_hop,
  output logic [dsdv_pkg::COST_W-1:0] out_entry_cost,
  output logic [dsdv_pkg::SEQ_W-1:0]  out_entry_seq,
  output logic                        out_updated,
  output logic                        out_batch_changed_out
);

  dsdv_pkg::cmd_t cmd;
  dsdv_pkg::sts_t sts;

  dsdv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsdv_dpath u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_addr              (cfg_addr),
    .cfg_wdata             (cfg_wdata),
    .in_mode               (in_mode),
    .in_node_id            (in_node_id),
    .in_dest_id            (in_dest_id),
    .in_cost               (in_cost),
    .in_seq_in             (in_seq_in),
    .in_link_down          (in_link_down),
    .in_last_of_batch      (in_last_of_batch),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_entry_valid       (out_entry_valid),
    .out_entry_next_hop    (out_entry_next_hop),
    .out_entry_cost        (out_entry_cost),
    .out_entry_seq         (out_entry_seq),
    .out_updated           (out_updated),
    .out_batch_changed_out (out_batch_changed_out)
  );

endmodule

// ===== bench/dsdv_route_table_engine_tb.sv =====
// Testbench for the route table engine: directed table, then random traffic against a predictor.
module dsdv_route_table_engine_tb;

  localparam logic [1:0] MODE_BAD = 2'd3;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [dsdv_pkg::ID_W-1:0]   node_id;
    logic [dsdv_pkg::ID_W-1:0]   dest_id;
    logic [dsdv_pkg::COST_W-1:0] cost;
    logic [dsdv_pkg::SEQ_W-1:0]  seq_in;
    logic                        link_down;
    logic                        last_of_batch;
  } req_t;

  typedef struct packed {
    logic                        entry_valid;
    logic [dsdv_pkg::ID_W-1:0]   next_hop;
    logic [dsdv_pkg::COST_W-1:0] cost;
    logic [dsdv_pkg::SEQ_W-1:0]  seq;
    logic                        updated;
    logic                        batch_changed;
  } entry_rsp_t;

  // Directed row: a request plus an optional typed-in expectation
  typedef struct {
    req_t       req;
    bit         has_exp;
    entry_rsp_t exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_addr = dsdv_pkg::CFG_SELF;
  logic [dsdv_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  entry_rsp_t out_rsp;

  // Predictor state
  logic                        rt_valid [dsdv_pkg::NODES];
  logic [dsdv_pkg::ID_W-1:0]   rt_hop   [dsdv_pkg::NODES];
  logic [dsdv_pkg::COST_W-1:0] rt_cost  [dsdv_pkg::NODES];
  logic [dsdv_pkg::SEQ_W-1:0]  rt_seq   [dsdv_pkg::NODES];
  logic [dsdv_pkg::COST_W-1:0] nb_cost  [dsdv_pkg::NODES];
  logic                        pend_batch;
  logic [dsdv_pkg::ID_W-1:0]   my_id;
  logic [dsdv_pkg::COST_W-1:0] inf_cost;

  entry_rsp_t exp_entries[$];
  int errors = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  bit rcv_hold = 0;

  always #6 clk = ~clk;

  dsdv_route_table_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_req.mode), .in_node_id(in_req.node_id), .in_dest_id(in_req.dest_id),
    .in_cost(in_req.cost), .in_seq_in(in_req.seq_in), .in_link_down(in_req.link_down),
    .in_last_of_batch(in_req.last_of_batch),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_entry_valid(out_rsp.entry_valid), .out_entry_next_hop(out_rsp.next_hop),
    .out_entry_cost(out_rsp.cost), .out_entry_seq(out_rsp.seq),
    .out_updated(out_rsp.updated), .out_batch_changed_out(out_rsp.batch_changed)
  );

  function automatic void clear_routes();
    for (int i = 0; i < dsdv_pkg::NODES; i++) begin
      rt_valid[i] = 1'b0; rt_hop[i] = '0; rt_cost[i] = '0; rt_seq[i] = '0;
      nb_cost[i] = dsdv_pkg::INF_RESET;
    end
    pend_batch = 1'b0;
    my_id = '0;
    inf_cost = dsdv_pkg::INF_RESET;
  endfunction

  function automatic entry_rsp_t entry_of(logic [dsdv_pkg::ID_W-1:0] id, logic upd, logic bc);
    entry_rsp_t r;
    r.entry_valid = rt_valid[id];
    r.next_hop = rt_hop[id];
    r.cost = rt_cost[id];
    r.seq = rt_seq[id];
    r.updated = upd;
    r.batch_changed = bc;
    return r;
  endfunction

  // Apply one request to the predicted tables and return the expected entry
  function automatic entry_rsp_t route_update(req_t q);
    logic [16:0] sum;
    logic [dsdv_pkg::COST_W-1:0] c, lc;
    logic upd, bc;
    logic [dsdv_pkg::ID_W-1:0] nb, dst;
    upd = 1'b0;
    bc = 1'b0;
    nb = q.node_id;
    dst = q.dest_id;
    case (q.mode)
      dsdv_pkg::MODE_ADV: begin
        if (dst != my_id) begin
          sum = {1'b0, q.cost} + {1'b0, nb_cost[nb]};
          c = (sum > {1'b0, inf_cost}) ? inf_cost : sum[dsdv_pkg::COST_W-1:0];
          if (!rt_valid[dst] || rt_seq[dst] < q.seq_in ||
              (rt_seq[dst] == q.seq_in && rt_cost[dst] > c)) begin
            rt_valid[dst] = 1'b1; rt_hop[dst] = nb; rt_cost[dst] = c;
            rt_seq[dst] = q.seq_in;
            upd = 1'b1;
          end
        end
        return entry_of(dst, upd, 1'b0);
      end
      dsdv_pkg::MODE_LINK: begin
        lc = q.link_down ? inf_cost : ((q.cost > inf_cost) ? inf_cost : q.cost);
        if (nb_cost[nb] < inf_cost) begin
          if (q.link_down) begin
            rt_seq[nb] = rt_seq[nb] + 1;
            upd = 1'b1;
          end
          if (nb_cost[nb] != lc) begin
            upd = 1'b1;
            nb_cost[nb] = lc;
            if (rt_valid[nb]) begin
              for (int i = 0; i < dsdv_pkg::NODES; i++)
                if (rt_valid[i] && rt_hop[i] == nb) rt_cost[i] = inf_cost;
              rt_cost[nb] = lc;
            end
          end
        end else if (!q.link_down) begin
          nb_cost[nb] = lc;
          upd = 1'b1;
        end
        if (upd) pend_batch = 1'b1;
        if (q.last_of_batch) begin
          bc = pend_batch;
          if (pend_batch) begin
            rt_seq[my_id] = rt_seq[my_id] + 2;
            upd = 1'b1;
          end
          pend_batch = 1'b0;
        end
        return entry_of(nb, upd, bc);
      end
      default: return entry_of(dst, 1'b0, 1'b0);
    endcase
  endfunction

  function automatic req_t mk_req(logic [1:0] m, int nb, int dst, int c, logic [31:0] s,
                                  bit dn, bit last);
    req_t q;
    q.mode = m;
    q.node_id = dsdv_pkg::ID_W'(nb);
    q.dest_id = dsdv_pkg::ID_W'(dst);
    q.cost = dsdv_pkg::COST_W'(c);
    q.seq_in = s;
    q.link_down = dn; q.last_of_batch = last;
    return q;
  endfunction

  task automatic write_cfg(logic idx, logic [dsdv_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dsdv_pkg::CFG_SELF) my_id = val[dsdv_pkg::ID_W-1:0];
    else inf_cost = val;
    @(posedge clk);
  endtask

  // Offer one item and hold it until accepted
  task automatic send_item(req_t q, bit has_exp = 0, entry_rsp_t typed = '0);
    entry_rsp_t e;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= q;
    do @(posedge clk); while (!in_ready);
    e = route_update(q);
    if (has_exp && e != typed) begin
      $error("directed row disagrees with predictor: exp %h got %h", typed, e);
      errors++;
    end
    exp_entries.push_back(e);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_entries.size() != 0) @(posedge clk);
    repeat (dsdv_pkg::NODES + 20) @(posedge clk);
  endtask

  // Mostly well-formed traffic: adverts over a few live neighbors, link batches, reads
  task automatic random_items(int n);
    req_t q;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      q = mk_req(dsdv_pkg::MODE_ADV, $urandom_range(7), $urandom_range(15),
                 $urandom_range(40), $urandom_range(6), 0, 0);
      if (k < 8) begin
        q = mk_req(2'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
                   1'($urandom_range(1)), 1'($urandom_range(1)));
      end else if (k < 30) begin
        q.mode = dsdv_pkg::MODE_LINK;
        q.link_down = ($urandom_range(4) == 0);
        q.cost = ($urandom_range(9) == 0) ? dsdv_pkg::COST_W'($urandom) :
                                             dsdv_pkg::COST_W'($urandom_range(20));
        q.last_of_batch = 1'($urandom_range(1));
      end else if (k < 42) begin
        q.mode = dsdv_pkg::MODE_READ;
      end else if (k < 50) begin
        q.seq_in = $urandom;
        q.cost = dsdv_pkg::COST_W'($urandom);
      end
      send_item(q);
    end
  endtask

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (rcv_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    entry_rsp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (exp_entries.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        e = exp_entries.pop_front();
        if (e.entry_valid !== out_rsp.entry_valid) begin
          $error("entry_valid exp %0d got %0d", e.entry_valid, out_rsp.entry_valid); errors++;
        end
        if (e.next_hop !== out_rsp.next_hop) begin
          $error("entry_next_hop exp %0d got %0d", e.next_hop, out_rsp.next_hop); errors++;
        end
        if (e.cost !== out_rsp.cost) begin
          $error("entry_cost exp %0d got %0d", e.cost, out_rsp.cost); errors++;
        end
        if (e.seq !== out_rsp.seq) begin
          $error("entry_seq exp %0d got %0d", e.seq, out_rsp.seq); errors++;
        end
        if (e.updated !== out_rsp.updated) begin
          $error("updated exp %0d got %0d", e.updated, out_rsp.updated); errors++;
        end
        if (e.batch_changed !== out_rsp.batch_changed) begin
          $error("batch_changed_out exp %0d got %0d", e.batch_changed,
                 out_rsp.batch_changed); errors++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    #30000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    entry_rsp_t z;
    z = '0;
    clear_routes();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset reads, extremes, each mode and special case
    rows.push_back('{mk_req(dsdv_pkg::MODE_READ, 0, 63, 0, 0, 0, 0), 1, z});
    rows.push_back('{mk_req(MODE_BAD, 63, 5, 16'hFFFF, '1, 1, 1), 1, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_ADV, 1, 0, 5, 9, 0, 0), 1, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_ADV, 1, 2, 5, 9, 0, 0), 1,
                     '{1'b1, 6'd1, 16'hFFFF, 32'd9, 1'b1, 1'b0}});
    rows.push_back('{mk_req(dsdv_pkg::MODE_LINK, 1, 0, 3, 0, 0, 0), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_ADV, 1, 1, 0, 4, 0, 0), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_ADV, 1, 2, 4, 9, 0, 0), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_ADV, 1, 3, 16'hFFFF, '1, 0, 0), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_ADV, 2, 3, 1, '1, 0, 0), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_ADV, 1, 2, 1, 9, 0, 0), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_LINK, 2, 0, 7, 0, 0, 0), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_LINK, 1, 0, 10, 0, 0, 1), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_LINK, 1, 0, 10, 0, 0, 1), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_LINK, 1, 0, 10, 0, 1, 0), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_LINK, 1, 0, 10, 0, 1, 1), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_LINK, 1, 0, 16'hFFFF, 0, 0, 1), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_READ, 0, 0, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_READ, 0, 2, 0, 0, 0, 0), 0, z});
    rows.push_back('{mk_req(dsdv_pkg::MODE_ADV, 63, 63, 16'hFFFF, '1, 1, 1), 0, z});
    foreach (rows[i]) send_item(rows[i].req, rows[i].has_exp, rows[i].exp);
    drain();

    // Sender idles lightly, receiver heavily; small infinity
    write_cfg(dsdv_pkg::CFG_SELF, 5);
    write_cfg(dsdv_pkg::CFG_INF, 30);
    snd_idle_pct = 19; rcv_idle_pct = 63;
    random_items(400);
    drain();

    // Long receiver hold-off while items keep coming
    fork
      begin
        rcv_hold = 1;
        repeat (300) @(posedge clk);
        rcv_hold = 0;
      end
      random_items(30);
    join
    drain();

    // Swap idling, zero infinity extreme briefly, then top self id
    write_cfg(dsdv_pkg::CFG_INF, 0);
    snd_idle_pct = 63; rcv_idle_pct = 19;
    random_items(60);
    drain();
    write_cfg(dsdv_pkg::CFG_SELF, 63);
    write_cfg(dsdv_pkg::CFG_INF, 16'hFFFF);
    random_items(400);
    drain();

    // No idling, mid values
    write_cfg(dsdv_pkg::CFG_SELF, 0);
    write_cfg(dsdv_pkg::CFG_INF, 1000);
    snd_idle_pct = 0; rcv_idle_pct = 0;
    random_items(400);
    drain();

    if (errors == 0 && exp_entries.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/dsdv_pkg.sv
rtl/dsdv_ctrl.sv
rtl/dsdv_dpath.sv
rtl/dsdv_route_table_engine.sv
bench/dsdv_route_table_engine_tb.sv
